// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/otcc_pkg.sv =====
package otcc_pkg;

	localparam int HALF_W     = 7;
	localparam int COORD_IN_W = 6;
	localparam int NUM_ORBITS = 3;
	localparam int NUM_ROT    = 4;
	localparam int HALF_RESET = 37;

	// Input beat: six 6-bit coordinates, padded to whole bytes.
	localparam int S_TDATA_W = 40;
	// Output beat: collinear, out_of_range, padded to one byte.
	localparam int M_TDATA_W = 8;

	// Bit positions in the output beat.
	localparam int M_COLLINEAR_BIT = 0;
	localparam int M_RANGE_BIT     = 1;

	typedef logic [COORD_IN_W-1:0] coord_in_t;
	typedef logic [HALF_W-1:0]     half_t;

endpackage

// ===== rtl/orbit_triple_collinearity_check.sv =====
// Orbit triple collinearity check. One beat carries three quarter-turn orbit
// representatives (row, column); each expands to its four rotated points on the
// grid of side 2*half_size, and all 64 choices of one point per orbit go
// through the exact cross-product test. The result beat says whether any choice
// is collinear, and flags a coordinate not below half_size (collinear is then
// 0). Throughput is one beat per clock unless m_tready stalls the output. The
// check runs as a five-stage pipeline: input capture and range check, rotation,
// coordinate differences, 64 parallel cross-product lanes (one pair of small
// multipliers each) with compare, then an OR reduce into the output register.
// Each stage moves when the one after it is empty or moving, so bubbles
// collapse and stalls drop nothing. The user must write half_size through
// cfg_we/cfg_wdata only while the pipe is empty; the block does not enforce
// this. Values above MAX_HALF saturate to MAX_HALF. Reset value is 37.
`include "assert_macros.svh"

module orbit_triple_collinearity_check #(
	parameter int MAX_HALF = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [otcc_pkg::HALF_W-1:0]       cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [5:0] first_row, [11:6] first_col, [17:12] second_row,
	// [23:18] second_col, [29:24] third_row, [35:30] third_col, [39:36] zero
	input  logic [otcc_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] collinear, [1] out_of_range, [7:2] zero
	output logic [otcc_pkg::M_TDATA_W-1:0]    m_tdata
);
	import otcc_pkg::*;

	// Largest half size the register can hold: the saturation bound capped by
	// the 7-bit field, or the reset value where that is larger.
	localparam int HALF_FIELD_MAX = (1 << HALF_W) - 1;
	localparam int HSAT = (MAX_HALF < HALF_FIELD_MAX) ? MAX_HALF : HALF_FIELD_MAX;
	localparam int HEFF = (HSAT > HALF_RESET) ? HSAT : HALF_RESET;
	// Grid coordinates run up to 2*HEFF-1.
	localparam int CW   = $clog2(2 * HEFF);
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * DW;
	localparam int NCH  = NUM_ROT * NUM_ROT * NUM_ROT;

	// Configuration register, saturated on write.
	half_t half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_W'(HALF_RESET);
		end else if (cfg_we) begin
			if (32'(cfg_wdata) > MAX_HALF)
				half_q <= HALF_W'(MAX_HALF);
			else
				half_q <= cfg_wdata;
		end
	end

	// Valid bits and the collapsing ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || m_tready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: unpack the beat, check range, form n-1.
	coord_in_t row_d [NUM_ORBITS];
	coord_in_t col_d [NUM_ORBITS];
	logic      bad_d;

	always_comb begin
		bad_d = 1'b0;
		for (int o = 0; o < NUM_ORBITS; o++) begin
			row_d[o] = s_tdata[(2*o)*COORD_IN_W +: COORD_IN_W];
			col_d[o] = s_tdata[(2*o+1)*COORD_IN_W +: COORD_IN_W];
			if ({1'b0, row_d[o]} >= half_q || {1'b0, col_d[o]} >= half_q)
				bad_d = 1'b1;
		end
	end

	coord_in_t      row_s1 [NUM_ORBITS];
	coord_in_t      col_s1 [NUM_ORBITS];
	logic           bad_s1;
	logic [CW-1:0]  nm1_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			row_s1 <= row_d;
			col_s1 <= col_d;
			bad_s1 <= bad_d;
			// Wraps for a zero half size; every coordinate is flagged then.
			nm1_s1 <= CW'({1'b0, half_q, 1'b0} - {{(HALF_W+1){1'b0}}, 1'b1});
		end
	end

	// Stage 2: the four rotated points of each orbit.
	logic [CW-1:0] px_s2 [NUM_ORBITS][NUM_ROT];
	logic [CW-1:0] py_s2 [NUM_ORBITS][NUM_ROT];
	logic          bad_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			for (int o = 0; o < NUM_ORBITS; o++) begin
				px_s2[o][0] <= CW'(row_s1[o]);
				py_s2[o][0] <= CW'(col_s1[o]);
				px_s2[o][1] <= CW'(col_s1[o]);
				py_s2[o][1] <= nm1_s1 - CW'(row_s1[o]);
				px_s2[o][2] <= nm1_s1 - CW'(row_s1[o]);
				py_s2[o][2] <= nm1_s1 - CW'(col_s1[o]);
				px_s2[o][3] <= nm1_s1 - CW'(col_s1[o]);
				py_s2[o][3] <= CW'(row_s1[o]);
			end
			bad_s2 <= bad_s1;
		end
	end

	// Stage 3: differences against the first orbit's point.
	logic signed [DW-1:0] dx21_s3 [NUM_ROT][NUM_ROT];
	logic signed [DW-1:0] dy21_s3 [NUM_ROT][NUM_ROT];
	logic signed [DW-1:0] dx31_s3 [NUM_ROT][NUM_ROT];
	logic signed [DW-1:0] dy31_s3 [NUM_ROT][NUM_ROT];
	logic                 bad_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int a = 0; a < NUM_ROT; a++) begin
				for (int b = 0; b < NUM_ROT; b++) begin
					dx21_s3[a][b] <= $signed({1'b0, px_s2[1][b]}) - $signed({1'b0, px_s2[0][a]});
					dy21_s3[a][b] <= $signed({1'b0, py_s2[1][b]}) - $signed({1'b0, py_s2[0][a]});
					dx31_s3[a][b] <= $signed({1'b0, px_s2[2][b]}) - $signed({1'b0, px_s2[0][a]});
					dy31_s3[a][b] <= $signed({1'b0, py_s2[2][b]}) - $signed({1'b0, py_s2[0][a]});
				end
			end
			bad_s3 <= bad_s2;
		end
	end

	// Stage 4: one cross-product lane per choice of rotations.
	logic [NCH-1:0] eq_d;

	for (genvar a = 0; a < NUM_ROT; a++) begin : g_a
		for (genvar b = 0; b < NUM_ROT; b++) begin : g_b
			for (genvar k = 0; k < NUM_ROT; k++) begin : g_k
				logic signed [PW-1:0] lhs;
				logic signed [PW-1:0] rhs;
				assign lhs = PW'(dx21_s3[a][b]) * PW'(dy31_s3[a][k]);
				assign rhs = PW'(dx31_s3[a][k]) * PW'(dy21_s3[a][b]);
				assign eq_d[(a*NUM_ROT + b)*NUM_ROT + k] = (lhs == rhs);
			end
		end
	end

	logic [NCH-1:0] eq_s4;
	logic           bad_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			eq_s4  <= eq_d;
			bad_s4 <= bad_s3;
		end
	end

	// Stage 5: reduce the lanes; a range fault forces collinear low.
	logic coll_s5;
	logic bad_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			coll_s5 <= (|eq_s4) && !bad_s4;
			bad_s5  <= bad_s4;
		end
	end

	always_comb begin
		m_tdata                  = '0;
		m_tdata[M_COLLINEAR_BIT] = coll_s5;
		m_tdata[M_RANGE_BIT]     = bad_s5;
	end
	assign m_tvalid = v_s5;

	`ASSERT_CLK(a_range_forces_clear, clk, arst_n, m_tvalid |-> !(coll_s5 && bad_s5), "collinear set with range fault")
	`ASSERT_CLK(a_accept_fills_s1, clk, arst_n, (s_tvalid && s_tready) |=> v_s1, "accepted beat not captured")
	`ASSERT_CLK(a_stall_holds_s3, clk, arst_n, (v_s3 && !rdy4) |=> v_s3, "stage 3 lost a beat under stall")
	`ASSERT_CLK(a_half_bounded, clk, arst_n, 32'(half_q) <= HEFF, "half size above its bound")

endmodule
